/* sv/sfc_pkg.sv */
package sfc_pkg;

  // Field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;
  localparam int unsigned TempW = 15;
  localparam int unsigned HumW  = 14;

  // CRC-8 check: polynomial x^8 + x^5 + x^4 + 1, zero seed, MSB first
  localparam logic [ByteW-1:0] CrcPoly = 8'h31;
  localparam logic [ByteW-1:0] CrcInit = 8'h00;

  // Conversion constants, all in hundredths
  localparam logic [TempW-1:0] TempSpan   = 15'd16500;
  localparam logic [TempW-1:0] TempOffset = 15'd4000;
  localparam logic [HumW-1:0]  HumSpan    = 14'd10000;

  // Product widths of word times span
  localparam int unsigned TempProdW = WordW + TempW;
  localparam int unsigned HumProdW  = WordW + HumW;

  // Stream payload widths
  localparam int unsigned InDataW  = 6 * ByteW;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned OutUserW = 1;

  // One converted frame
  typedef struct packed {
    logic                    frame_bad;
    logic [HumW-1:0]         hum_centi;
    logic signed [TempW-1:0] temp_centi;
  } sfc_result_t;

  // One byte through the CRC-8 register, MSB first
  function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc_in,
                                                 input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < ByteW; b++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* sv/sfc_word_check.sv */
module sfc_word_check import sfc_pkg::*; (
  input  logic [WordW-1:0] word_i,
  input  logic [ByteW-1:0] check_i,
  output logic             bad_o
);

  logic [ByteW-1:0] crc_hi;
  logic [ByteW-1:0] crc_full;

  // CRC over high byte, then low byte
  assign crc_hi   = crc8_byte(CrcInit, word_i[WordW-1:ByteW]);
  assign crc_full = crc8_byte(crc_hi, word_i[ByteW-1:0]);

  // A zero word passes the CRC but is never a valid reading
  assign bad_o = (crc_full != check_i) || (word_i == '0);

endmodule

/* sv/sfc_scale.sv */
module sfc_scale import sfc_pkg::*; (
  input  logic [WordW-1:0] temp_word_i,
  input  logic [WordW-1:0] hum_word_i,
  input  logic             bad_i,
  output sfc_result_t      result_o
);

  logic [TempProdW-1:0] temp_prod;
  logic [TempProdW:0]   temp_sum;
  logic [TempW-1:0]     temp_quo;
  logic [HumProdW-1:0]  hum_prod;
  logic [HumProdW:0]    hum_sum;
  logic [HumW-1:0]      hum_quo;

  // Scale raw words by their spans
  assign temp_prod = TempProdW'(temp_word_i) * TempProdW'(TempSpan);
  assign hum_prod  = HumProdW'(hum_word_i) * HumProdW'(HumSpan);

  // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for quotients up to 65536
  assign temp_sum = (TempProdW+1)'(temp_prod) + (TempProdW+1)'(temp_prod[TempProdW-1:WordW])
                  + (TempProdW+1)'(1);
  assign hum_sum  = (HumProdW+1)'(hum_prod) + (HumProdW+1)'(hum_prod[HumProdW-1:WordW])
                  + (HumProdW+1)'(1);

  assign temp_quo = temp_sum[WordW+TempW-1:WordW];
  assign hum_quo  = hum_sum[WordW+HumW-1:WordW];

  // Bad frames report zero for both readings
  always_comb begin
    result_o.frame_bad = bad_i;
    if (bad_i) begin
      result_o.temp_centi = '0;
      result_o.hum_centi  = '0;
    end else begin
      result_o.temp_centi = $signed(temp_quo - TempOffset);
      result_o.hum_centi  = hum_quo;
    end
  end

endmodule

/* sv/sensor_frame_check_convert.sv */
// Sensor frame check and convert. Each input transfer carries one six-byte
// frame (temperature word, its CRC-8 byte, humidity word, its CRC-8 byte);
// each output transfer carries temperature in hundredths of a degree
// (signed, -4000..12500), humidity in hundredths of a percent (0..10000) and
// a bad-frame flag on tuser, set when a CRC byte mismatches or a raw word is
// zero, in which case both readings are zero. A frame can be taken every
// cycle while the downstream side keeps tready high; its result is presented
// on the output from the result register, with the CRC checks and the
// constant-multiply conversion between the input register and the result
// register. Both registers advance whenever the output side is empty or
// being taken, so throughput is one frame per cycle as long as the
// downstream side keeps tready high.
module sensor_frame_check_convert import sfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // temp_high_byte, temp_low_byte, temp_check, hum_high_byte, hum_low_byte, hum_check
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // temp_centi [14:0], hum_centi [28:15], zeros [31:29]
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // frame_bad [0]
  output logic [OutUserW-1:0] m_axis_tuser_o
);

  logic               in_valid_q, in_valid_d;
  logic [InDataW-1:0] in_data_q;
  logic               out_valid_q, out_valid_d;
  sfc_result_t        out_res_q;
  logic               out_adv;
  logic               in_take;
  logic [WordW-1:0]   temp_word;
  logic [WordW-1:0]   hum_word;
  logic [ByteW-1:0]   temp_check;
  logic [ByteW-1:0]   hum_check;
  logic               temp_bad;
  logic               hum_bad;
  sfc_result_t        res;

  // Pipeline flow control
  assign out_adv         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || out_adv;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_valid_d      = in_take ? 1'b1 : (out_adv ? 1'b0 : in_valid_q);
  assign out_valid_d     = out_adv ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= s_axis_tdata_i;
    end
  end

  // Frame unpacking
  assign temp_word  = {in_data_q[0*ByteW +: ByteW], in_data_q[1*ByteW +: ByteW]};
  assign temp_check = in_data_q[2*ByteW +: ByteW];
  assign hum_word   = {in_data_q[3*ByteW +: ByteW], in_data_q[4*ByteW +: ByteW]};
  assign hum_check  = in_data_q[5*ByteW +: ByteW];

  sfc_word_check u_temp_check (
    .word_i  (temp_word),
    .check_i (temp_check),
    .bad_o   (temp_bad)
  );

  sfc_word_check u_hum_check (
    .word_i  (hum_word),
    .check_i (hum_check),
    .bad_o   (hum_bad)
  );

  sfc_scale u_scale (
    .temp_word_i (temp_word),
    .hum_word_i  (hum_word),
    .bad_i       (temp_bad || hum_bad),
    .result_o    (res)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_adv && in_valid_q) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDataW-TempW-HumW)'(0), out_res_q.hum_centi,
                            out_res_q.temp_centi};
  assign m_axis_tuser_o  = out_res_q.frame_bad;

endmodule

/* sv/sfc_checker.sv */
module sfc_checker import sfc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic [OutUserW-1:0] m_axis_tuser_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // Empty output side never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input not ready while output empty");

  // A taken frame shows up on the output side
  a_in_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> ##1 m_axis_tvalid_o)
    else $error("taken frame did not reach the output");

  // Bad frame gives zero readings
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("bad frame with nonzero readings");

  // Good frame humidity reading stays in range, padding is zero
  a_good_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |->
      m_axis_tdata_o[TempW+HumW-1:TempW] <= HumSpan &&
      m_axis_tdata_o[OutDataW-1:TempW+HumW] == '0)
    else $error("good frame reading out of range");

endmodule

bind sensor_frame_check_convert sfc_checker u_sfc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

/* tb/frame_result_check.sv */
// Watches both stream channels of the frame converter, works out the reading
// for every frame taken in and compares it with the next reading handed out.
module frame_result_check import sfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic [OutUserW-1:0] m_tuser_i,
  output int                  mismatch_cnt_o,
  output int                  pending_o
);

  localparam longint FullScale = 65535;
  localparam int     ReportMax = 10;

  // readings still owed by the block, oldest first
  sfc_result_t expected_readings[$];

  // CRC-8 of one raw word, fed one bit at a time, high bit first
  function automatic logic [ByteW-1:0] word_crc(input logic [WordW-1:0] w);
    logic [ByteW-1:0] r;
    logic             fb;
    r = CrcInit;
    for (int i = WordW - 1; i >= 0; i--) begin
      fb = r[ByteW-1] ^ w[i];
      r  = {r[ByteW-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
    end
    return r;
  endfunction

  // Reading that one frame must turn into
  function automatic sfc_result_t convert_frame(input logic [InDataW-1:0] frame);
    logic [WordW-1:0] t_word;
    logic [WordW-1:0] h_word;
    logic [ByteW-1:0] t_chk;
    logic [ByteW-1:0] h_chk;
    longint           t_scaled;
    longint           h_scaled;
    sfc_result_t      r;
    t_word = {frame[7:0], frame[15:8]};
    t_chk  = frame[23:16];
    h_word = {frame[31:24], frame[39:32]};
    h_chk  = frame[47:40];
    r = '0;
    // a zero word is refused even when its check byte fits
    r.frame_bad = (word_crc(t_word) != t_chk) || (t_word == '0) ||
                  (word_crc(h_word) != h_chk) || (h_word == '0);
    if (!r.frame_bad) begin
      t_scaled     = (longint'(t_word) * longint'(TempSpan)) / FullScale
                     - longint'(TempOffset);
      h_scaled     = (longint'(h_word) * longint'(HumSpan)) / FullScale;
      r.temp_centi = t_scaled[TempW-1:0];
      r.hum_centi  = h_scaled[HumW-1:0];
    end
    return r;
  endfunction

  // Track frames in, compare readings out
  always @(posedge clk_i) begin : watch
    sfc_result_t             want;
    logic signed [TempW-1:0] got_temp;
    logic [HumW-1:0]         got_hum;
    logic [OutDataW-TempW-HumW-1:0] got_pad;
    logic                    got_bad;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) begin
        expected_readings.push_back(convert_frame(s_tdata_i));
      end
      if (m_tvalid_i && m_tready_i) begin
        got_temp = m_tdata_i[TempW-1:0];
        got_hum  = m_tdata_i[TempW +: HumW];
        got_pad  = m_tdata_i[OutDataW-1:TempW+HumW];
        got_bad  = m_tuser_i[0];
        if (expected_readings.size() == 0) begin
          if (mismatch_cnt_o < ReportMax) begin
            $display("unexpected reading: temp %0d hum %0d bad %0b",
                     got_temp, got_hum, got_bad);
          end
          mismatch_cnt_o++;
        end else begin
          want = expected_readings.pop_front();
          if (got_temp !== want.temp_centi || got_hum !== want.hum_centi ||
              got_bad !== want.frame_bad || got_pad !== '0) begin
            if (mismatch_cnt_o < ReportMax) begin
              $display("reading mismatch: temp exp %0d got %0d, hum exp %0d got %0d,",
                       want.temp_centi, got_temp, want.hum_centi, got_hum);
              $display("  bad exp %0b got %0b, pad bits %0h",
                       want.frame_bad, got_bad, got_pad);
            end
            mismatch_cnt_o++;
          end
        end
      end
      pending_o = expected_readings.size();
    end else begin
      mismatch_cnt_o = 0;
      pending_o      = 0;
    end
  end

endmodule

/* tb/tb.sv */
// Drives sensor frames into the converter and paces the result side; the
// checker beside the block does the predicting and comparing.
module tb;
  import sfc_pkg::*;

  localparam int RandFrames = 1200;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 80;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic [OutUserW-1:0] m_tuser;

  int mismatches;
  int pending;
  bit hold_req = 1'b0;
  bit idle_on  = 1'b1;

  always #6 clk = ~clk;

  sensor_frame_check_convert uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  frame_result_check res_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_tvalid_i     (s_tvalid),
    .s_tready_i     (s_tready),
    .s_tdata_i      (s_tdata),
    .m_tvalid_i     (m_tvalid),
    .m_tready_i     (m_tready),
    .m_tdata_i      (m_tdata),
    .m_tuser_i      (m_tuser),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending)
  );

  // check byte a sensor would send for a word
  function automatic logic [ByteW-1:0] word_check(input logic [WordW-1:0] w);
    return crc8_byte(crc8_byte(CrcInit, w[15:8]), w[7:0]);
  endfunction

  function automatic logic [InDataW-1:0] frame_of(input logic [WordW-1:0] t,
                                                  input logic [ByteW-1:0] tc,
                                                  input logic [WordW-1:0] h,
                                                  input logic [ByteW-1:0] hc);
    return {hc, h[7:0], h[15:8], tc, t[7:0], t[15:8]};
  endfunction

  function automatic logic [InDataW-1:0] good_frame(input logic [WordW-1:0] t,
                                                    input logic [WordW-1:0] h);
    return frame_of(t, word_check(t), h, word_check(h));
  endfunction

  // nonzero word, leaning on the ends of the range and the zero crossing
  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0001;
      1:       return 16'hFFFF;
      2:       return WordW'(15886 + $urandom_range(0, 3));
      default: return WordW'($urandom_range(1, 65535));
    endcase
  endfunction

  // mostly well-formed frames, some noise, broken checks and zero words
  function automatic logic [InDataW-1:0] random_frame();
    logic [WordW-1:0]   t;
    logic [WordW-1:0]   h;
    logic [InDataW-1:0] f;
    int                 kind;
    t    = rand_word();
    h    = rand_word();
    f    = good_frame(t, h);
    kind = $urandom_range(0, 19);
    if (kind == 16) begin
      f = InDataW'({$urandom, $urandom});
    end else if (kind == 17) begin
      f[($urandom_range(0, 1) ? 40 : 16) + $urandom_range(0, 7)] ^= 1'b1;
    end else if (kind == 18) begin
      f = good_frame('0, h);
    end else if (kind == 19) begin
      f = good_frame(t, '0);
    end
    return f;
  endfunction

  // offer one frame and hold it until taken
  task automatic send_frame(input logic [InDataW-1:0] frame);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= frame;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic idle_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= InDataW'({$urandom, $urandom});
    end
  endtask

  // Result side pacing: long hold on request, random stalls, or always ready
  initial begin : result_pacer
    int hold_left;
    int stall_left;
    bit hold_done;
    hold_left  = 0;
    stall_left = 0;
    hold_done  = 1'b0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (!idle_on) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        m_tready   <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Run limit
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // Stimulus and verdict
  initial begin : stimulus
    logic [InDataW-1:0] directed[$];
    logic [WordW-1:0]   w;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    rst_n    = 1'b0;

    // ends of the ranges, zero crossing of temperature
    directed.push_back(good_frame(16'h0001, 16'h0001));
    directed.push_back(good_frame(16'hFFFF, 16'hFFFF));
    directed.push_back(good_frame(16'hFFFE, 16'hFFFE));
    directed.push_back(good_frame(16'h8000, 16'h8000));
    directed.push_back(good_frame(16'd15887, 16'd6553));
    directed.push_back(good_frame(16'd15888, 16'd6554));
    directed.push_back(good_frame(16'h00FF, 16'hFF00));
    // zero words whose check byte still fits
    directed.push_back(good_frame(16'h0000, 16'h1234));
    directed.push_back(good_frame(16'h1234, 16'h0000));
    directed.push_back(good_frame(16'h0000, 16'h0000));
    // broken check bytes, one word and both
    w = 16'h6A3C;
    directed.push_back(frame_of(w, word_check(w) ^ 8'h01, w, word_check(w)));
    directed.push_back(frame_of(w, word_check(w), w, word_check(w) ^ 8'h80));
    directed.push_back(frame_of(w, ~word_check(w), 16'h0000, 8'hFF));
    // raw byte extremes
    directed.push_back({InDataW{1'b1}});
    directed.push_back({InDataW{1'b0}});
    directed.push_back(good_frame(16'hFFFF, 16'h0001));
    directed.push_back(good_frame(16'h0001, 16'hFFFF));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      if (i % 4 == 3) idle_sender($urandom_range(1, 3));
      send_frame(directed[i]);
    end

    for (int i = 0; i < RandFrames; i++) begin
      idle_on = !((i >= 450 && i < 550) || i >= 1000);
      // result side stops for a long stretch while frames keep coming
      if (i == 470) hold_req = 1'b1;
      // let the pipe drain completely once
      if (i == 700) begin
        idle_sender(1);
        wait (pending == 0);
      end
      if (idle_on && $urandom_range(0, 4) == 0) idle_sender($urandom_range(1, 7));
      send_frame(random_frame());
    end

    idle_sender(1);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sfc_pkg.sv
sv/sfc_word_check.sv
sv/sfc_scale.sv
sv/sensor_frame_check_convert.sv
sv/sfc_checker.sv
tb/frame_result_check.sv
tb/tb.sv
